### rtl/hcl_pkg.sv
package hcl_pkg;

   localparam int STEPS_W   = 10;
   localparam int LEN_W     = 48;
   localparam int SEG_RESET = 15;
   localparam int Q_DEPTH   = 2;
   localparam int Q_PTR_W   = $clog2(Q_DEPTH);
   localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

   typedef struct packed {
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic signed [31:0] start_z;
      logic signed [31:0] end_x;
      logic signed [31:0] end_y;
      logic signed [31:0] end_z;
      logic signed [31:0] tangent_in_x;
      logic signed [31:0] tangent_in_y;
      logic signed [31:0] tangent_in_z;
      logic signed [31:0] tangent_out_x;
      logic signed [31:0] tangent_out_y;
      logic signed [31:0] tangent_out_z;
   } req_type;

   typedef struct packed {
      logic [LEN_W-1:0] curve_length;
      logic             length_saturated;
   } rsp_type;

   // one queued word: the curve plus the step count latched on acceptance
   typedef struct packed {
      req_type            curve;
      logic [STEPS_W-1:0] steps;
   } entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_T2,
      ST_T3,
      ST_SAMPLE,
      ST_SQ,
      ST_ROOT,
      ST_ADD,
      ST_DONE
   } state_type;

endpackage

### rtl/hcl_front.sv
module hcl_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write,
   input  logic [hcl_pkg::STEPS_W-1:0] csr_data,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  hcl_pkg::req_type          req_data,
   input  logic                      q_full,
   output logic                      push,
   output hcl_pkg::entry_type        push_data
);

   logic [hcl_pkg::STEPS_W-1:0] seg_ff;
   logic [hcl_pkg::STEPS_W-1:0] seg_in;

   assign seg_in = csr_write ? csr_data : seg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff <= hcl_pkg::STEPS_W'(hcl_pkg::SEG_RESET);
      end else begin
         seg_ff <= seg_in;
      end
   end

   assign req_stall       = q_full;
   assign push            = req_valid && !q_full;
   assign push_data.curve = req_data;
   assign push_data.steps = seg_ff;

endmodule

### rtl/hcl_queue.sv
module hcl_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  hcl_pkg::entry_type push_data,
   input  logic               pop,
   output logic               full,
   output logic               head_valid,
   output hcl_pkg::entry_type head
);

   hcl_pkg::entry_type             mem_ff [hcl_pkg::Q_DEPTH];
   logic [hcl_pkg::Q_PTR_W-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [hcl_pkg::Q_CNT_W-1:0]    cnt_ff, cnt_in;

   assign full       = (cnt_ff == hcl_pkg::Q_CNT_W'(hcl_pkg::Q_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head       = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == hcl_pkg::Q_PTR_W'(hcl_pkg::Q_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == hcl_pkg::Q_PTR_W'(hcl_pkg::Q_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

### rtl/hcl_back.sv
module hcl_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  hcl_pkg::entry_type q_head,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output hcl_pkg::rsp_type   rsp_data
);

   localparam int SW = 36;   // sample width
   localparam int XW = 74;   // sum of squares
   localparam int RW = 37;   // root
   localparam int AW = 56;   // product accumulator

   hcl_pkg::state_type state_ff, state_in;
   logic                phase_ff, phase_in;
   logic [9:0]          idx_ff, idx_in;
   logic [10:0]         drem_ff, drem_in;
   logic [16:0]         quo_ff, quo_in;
   logic [4:0]          dcnt_ff, dcnt_in;
   logic [16:0]         t2_ff, t2_in, t3_ff, t3_in;
   logic [1:0]          term_ff, term_in, axis_ff, axis_in;
   logic signed [AW-1:0] acc_ff, acc_in;
   logic signed [SW-1:0] prev_ff [3];
   logic signed [SW-1:0] prev_in [3];
   logic signed [SW-1:0] new_ff [3];
   logic signed [SW-1:0] new_in [3];
   logic [XW-1:0]       x_ff, x_in;
   logic [RW:0]         srem_ff, srem_in;
   logic [RW-1:0]       root_ff, root_in;
   logic [5:0]          rcnt_ff, rcnt_in;
   logic [hcl_pkg::LEN_W-1:0] len_ff, len_in;
   logic                sat_ff, sat_in;
   logic                out_valid_ff, out_valid_in;
   hcl_pkg::rsp_type    out_ff, out_in;

   logic signed [32:0]  mul_a;
   logic signed [19:0]  mul_b;
   logic signed [52:0]  p_ff;

   // basis values, Q.16
   logic signed [19:0]  t1s, t2s, t3s, h1, h2, h3, h4;
   logic [10:0]         num, den;
   logic [26:0]         dividend;
   logic [11:0]         dshift;
   logic signed [SW:0]  diff;
   logic [SW:0]         dabs;
   logic [17:0]         dhi, dlo;
   logic signed [AW-1:0] acc_sum;
   logic [RW+2:0]       rtry, rnew;
   logic [hcl_pkg::LEN_W:0] len_sum;

   function automatic logic signed [31:0] pick(hcl_pkg::req_type c, logic [1:0] term,
                                               logic [1:0] axis);
      logic signed [31:0] v;
      v = '0;
      case (term)
         2'd0: v = (axis == 2'd0) ? c.start_x : (axis == 2'd1) ? c.start_y : c.start_z;
         2'd1: v = (axis == 2'd0) ? c.end_x : (axis == 2'd1) ? c.end_y : c.end_z;
         2'd2: v = (axis == 2'd0) ? c.tangent_in_x :
                   (axis == 2'd1) ? c.tangent_in_y : c.tangent_in_z;
         default: v = (axis == 2'd0) ? c.tangent_out_x :
                      (axis == 2'd1) ? c.tangent_out_y : c.tangent_out_z;
      endcase
      return v;
   endfunction

   assign t1s = signed'({3'b0, quo_ff});
   assign t2s = signed'({3'b0, t2_ff});
   assign t3s = signed'({3'b0, t3_ff});
   assign h1  = (t3s <<< 1) - (t2s + (t2s <<< 1)) + 20'sd65536;
   assign h2  = (t2s + (t2s <<< 1)) - (t3s <<< 1);
   assign h3  = t3s - (t2s <<< 1) + t1s;
   assign h4  = t3s - t2s;

   assign num      = {1'b0, idx_ff} + 11'd1;
   assign den      = {1'b0, q_head.steps} + 11'd1;
   assign dividend = {num, 16'b0};
   assign dshift   = {drem_ff, dividend[dcnt_ff]};

   assign diff = {new_ff[axis_ff][SW-1], new_ff[axis_ff]}
               - {prev_ff[axis_ff][SW-1], prev_ff[axis_ff]};
   assign dabs = diff[SW] ? (SW+1)'(-diff) : (SW+1)'(diff);
   assign dhi  = dabs[SW-1:18];
   assign dlo  = dabs[17:0];

   assign acc_sum = acc_ff + AW'(p_ff);

   assign rnew = {srem_ff, x_ff[XW-1:XW-2]};
   assign rtry = {1'b0, root_ff, 2'b01};

   assign len_sum = {1'b0, len_ff} + (hcl_pkg::LEN_W+1)'(root_ff);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         hcl_pkg::ST_T2: begin
            mul_a = signed'({16'b0, quo_ff});
            mul_b = t1s;
         end
         hcl_pkg::ST_T3: begin
            mul_a = signed'({16'b0, t2_ff});
            mul_b = t1s;
         end
         hcl_pkg::ST_SAMPLE: begin
            mul_a = 33'(pick(q_head.curve, term_ff, axis_ff));
            case (term_ff)
               2'd0:    mul_b = h1;
               2'd1:    mul_b = h2;
               2'd2:    mul_b = h3;
               default: mul_b = h4;
            endcase
         end
         hcl_pkg::ST_SQ: begin
            mul_a = signed'({15'b0, (term_ff == 2'd2) ? dlo : dhi});
            mul_b = signed'({2'b0, (term_ff == 2'd0) ? dhi : dlo});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      p_ff <= mul_a * mul_b;
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      idx_in       = idx_ff;
      drem_in      = drem_ff;
      quo_in       = quo_ff;
      dcnt_in      = dcnt_ff;
      t2_in        = t2_ff;
      t3_in        = t3_ff;
      term_in      = term_ff;
      axis_in      = axis_ff;
      acc_in       = acc_ff;
      prev_in      = prev_ff;
      new_in       = new_ff;
      x_in         = x_ff;
      srem_in      = srem_ff;
      root_in      = root_ff;
      rcnt_in      = rcnt_ff;
      len_in       = len_ff;
      sat_in       = sat_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      pop          = 1'b0;

      case (state_ff)
         hcl_pkg::ST_IDLE: begin
            if (q_valid) begin
               idx_in     = '0;
               len_in     = '0;
               sat_in     = 1'b0;
               prev_in[0] = SW'(q_head.curve.start_x);
               prev_in[1] = SW'(q_head.curve.start_y);
               prev_in[2] = SW'(q_head.curve.start_z);
               drem_in    = '0;
               quo_in     = '0;
               dcnt_in    = 5'd26;
               state_in   = hcl_pkg::ST_DIV;
            end
         end
         // t = ((i+1) << 16) / (steps+1), one quotient bit a cycle
         hcl_pkg::ST_DIV: begin
            if (dshift >= {1'b0, den}) begin
               drem_in = 11'(dshift - {1'b0, den});
               quo_in  = {quo_ff[15:0], 1'b1};
            end else begin
               drem_in = dshift[10:0];
               quo_in  = {quo_ff[15:0], 1'b0};
            end
            dcnt_in = dcnt_ff - 1'b1;
            if (dcnt_ff == '0) begin
               state_in = hcl_pkg::ST_T2;
               phase_in = 1'b0;
            end
         end
         hcl_pkg::ST_T2: begin
            phase_in = !phase_ff;
            if (phase_ff) begin
               t2_in    = p_ff[32:16];
               state_in = hcl_pkg::ST_T3;
            end
         end
         hcl_pkg::ST_T3: begin
            phase_in = !phase_ff;
            if (phase_ff) begin
               t3_in    = p_ff[32:16];
               term_in  = '0;
               axis_in  = '0;
               acc_in   = '0;
               state_in = hcl_pkg::ST_SAMPLE;
            end
         end
         hcl_pkg::ST_SAMPLE: begin
            phase_in = !phase_ff;
            if (phase_ff) begin
               if (term_ff == 2'd3) begin
                  // arithmetic shift floors toward minus infinity
                  new_in[axis_ff] = acc_sum[SW+15:16];
                  acc_in  = '0;
                  term_in = '0;
                  if (axis_ff == 2'd2) begin
                     axis_in  = '0;
                     x_in     = '0;
                     state_in = hcl_pkg::ST_SQ;
                  end else begin
                     axis_in = axis_ff + 1'b1;
                  end
               end else begin
                  acc_in  = acc_sum;
                  term_in = term_ff + 1'b1;
               end
            end
         end
         // d^2 = hi^2 << 36 + 2*hi*lo << 18 + lo^2
         hcl_pkg::ST_SQ: begin
            phase_in = !phase_ff;
            if (phase_ff) begin
               case (term_ff)
                  2'd0:    x_in = x_ff + (XW'(p_ff[35:0]) << 36);
                  2'd1:    x_in = x_ff + (XW'(p_ff[35:0]) << 19);
                  default: x_in = x_ff + XW'(p_ff[35:0]);
               endcase
               if (term_ff == 2'd2) begin
                  term_in = '0;
                  if (axis_ff == 2'd2) begin
                     axis_in  = '0;
                     srem_in  = '0;
                     root_in  = '0;
                     rcnt_in  = 6'(RW - 1);
                     state_in = hcl_pkg::ST_ROOT;
                  end else begin
                     axis_in = axis_ff + 1'b1;
                  end
               end else begin
                  term_in = term_ff + 1'b1;
               end
            end
         end
         // digit-by-digit root, two radicand bits a cycle
         hcl_pkg::ST_ROOT: begin
            if (rnew >= rtry) begin
               srem_in = (RW+1)'(rnew - rtry);
               root_in = {root_ff[RW-2:0], 1'b1};
            end else begin
               srem_in = rnew[RW:0];
               root_in = {root_ff[RW-2:0], 1'b0};
            end
            x_in    = x_ff << 2;
            rcnt_in = rcnt_ff - 1'b1;
            if (rcnt_ff == '0) begin
               state_in = hcl_pkg::ST_ADD;
            end
         end
         hcl_pkg::ST_ADD: begin
            if (len_sum[hcl_pkg::LEN_W]) begin
               len_in = '1;
               sat_in = 1'b1;
            end else begin
               len_in = len_sum[hcl_pkg::LEN_W-1:0];
            end
            prev_in = new_ff;
            idx_in  = idx_ff + 1'b1;
            if (idx_ff == q_head.steps) begin
               state_in = hcl_pkg::ST_DONE;
            end else begin
               drem_in  = '0;
               quo_in   = '0;
               dcnt_in  = 5'd26;
               state_in = hcl_pkg::ST_DIV;
            end
         end
         hcl_pkg::ST_DONE: begin
            if (!out_valid_ff || !rsp_stall) begin
               out_in.curve_length     = len_ff;
               out_in.length_saturated = sat_ff;
               out_valid_in            = 1'b1;
               pop                     = 1'b1;
               state_in                = hcl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = hcl_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hcl_pkg::ST_IDLE;
         phase_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      drem_ff <= drem_in;
      quo_ff  <= quo_in;
      dcnt_ff <= dcnt_in;
      t2_ff   <= t2_in;
      t3_ff   <= t3_in;
      term_ff <= term_in;
      axis_ff <= axis_in;
      acc_ff  <= acc_in;
      prev_ff <= prev_in;
      new_ff  <= new_in;
      x_ff    <= x_in;
      srem_ff <= srem_in;
      root_ff <= root_in;
      rcnt_ff <= rcnt_in;
      len_ff  <= len_in;
      sat_ff  <= sat_in;
      out_ff  <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

### rtl/hermite_curve_length.sv
// channel   direction  word                    handshake
// req       in         hcl_pkg::req_type       req_valid / req_stall
// rsp       out        hcl_pkg::rsp_type       rsp_valid / rsp_stall
// csr       in         segment_count, 10 bits  csr_write
//
// Each sample runs a radix-2 divider for t, then two basis multiplies, twelve
// point products and nine square partial products on the one shared 33x20
// multiplier, then a digit-by-digit root. An item runs segment_count + 1
// samples in the back end. Reset is synchronous; segment_count resets to 15.
// The two-entry queue holds the curve in work plus one more; req_stall is
// high while both are taken.
module hermite_curve_length (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  hcl_pkg::req_type            req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output hcl_pkg::rsp_type            rsp_data,
   input  logic                        csr_write,
   input  logic [hcl_pkg::STEPS_W-1:0] csr_data
);

   logic               q_full, push, pop, q_valid;
   hcl_pkg::entry_type push_data, q_head;

   hcl_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_data  (csr_data),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .push      (push),
      .push_data (push_data)
   );

   hcl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .pop        (pop),
      .full       (q_full),
      .head_valid (q_valid),
      .head       (q_head)
   );

   hcl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
